@@ hw/rtl/ervt_pkg.sv @@
`default_nettype none
package ervt_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned VelW     = 32;
  localparam int unsigned StepW    = 8;
  localparam int unsigned TravelW  = 15;
  localparam int unsigned ScaledW  = 27;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PosW-1:0] CenterPos = 16'd32767;
  localparam int unsigned DistScale = 4084;
  localparam int unsigned VelScale  = 100;
  localparam int unsigned StepScale = DistScale * VelScale;

  localparam logic [CfgIdxW-1:0] CfgMinTravel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCountDir  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepDir    = 2'd2;

  // one classified item handed from the front end to the back end
  typedef struct packed {
    logic               is_start;
    logic               followed;
    logic               emit;
    logic [ScaledW-1:0] scaled;
    logic [TimeW-1:0]   elapsed;
    logic [PosW-1:0]    extreme;
  } ervt_cmd_t;

  typedef struct packed {
    logic [PosW-1:0] extreme;
    logic [VelW-1:0] mean;
    logic [VelW-1:0] peak;
  } ervt_res_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkVel,
    BkMean,
    BkMeanWait,
    BkPush
  } ervt_back_state_e;

endpackage
`default_nettype wire

@@ hw/rtl/ervt_front.sv @@
`default_nettype none
module ervt_front import ervt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               command_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [TimeW-1:0]   capture_time_i,
  output logic                    full_o,
  input  wire logic [TravelW-1:0] min_travel_i,
  input  wire logic               count_dir_i,
  input  wire logic               rep_dir_i,
  input  wire logic               q_pop_i,
  output logic                    q_valid_o,
  output ervt_cmd_t               q_entry_o
);

  logic [PosW-1:0]  prev_pos_q, prev_pos_d;
  logic [TimeW-1:0] prev_time_q, prev_time_d;
  logic [PosW-1:0]  extreme_q, extreme_d;
  logic             min_reached_q, min_reached_d;

  logic             accept;
  logic             followed;
  logic [StepW-1:0] step;
  logic [PosW-1:0]  extreme_next;
  logic [PosW-1:0]  low_bound, high_bound;
  logic             reached_now, reached, emit;
  ervt_cmd_t        entry;

  ervt_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign accept = push_i && !full_o;

  assign low_bound  = CenterPos - {1'b0, min_travel_i};
  assign high_bound = CenterPos + {1'b0, min_travel_i};

  always_comb begin
    if (count_dir_i) begin
      followed = position_i > prev_pos_q;
      step     = StepW'(position_i - prev_pos_q);
    end else begin
      followed = position_i < prev_pos_q;
      step     = StepW'(prev_pos_q - position_i);
    end

    if (rep_dir_i) begin
      extreme_next = (position_i > extreme_q) ? position_i : extreme_q;
      reached_now  = position_i >= high_bound;
    end else begin
      extreme_next = (position_i < extreme_q) ? position_i : extreme_q;
      reached_now  = position_i <= low_bound;
    end
    reached = min_reached_q || reached_now;
    // a repetition ends when the position is back inside the bound
    emit = reached && (rep_dir_i ? (position_i < high_bound) : (position_i > low_bound));

    entry.is_start = command_i;
    entry.followed = followed;
    entry.emit     = emit;
    entry.scaled   = ScaledW'(step) * ScaledW'(StepScale);
    entry.elapsed  = capture_time_i - prev_time_q;
    entry.extreme  = extreme_next;

    prev_pos_d    = prev_pos_q;
    prev_time_d   = prev_time_q;
    extreme_d     = extreme_q;
    min_reached_d = min_reached_q;
    if (accept) begin
      if (command_i) begin
        prev_pos_d  = CenterPos;
        prev_time_d = '0;
        extreme_d   = CenterPos;
      end else begin
        prev_pos_d    = position_i;
        prev_time_d   = capture_time_i;
        extreme_d     = emit ? CenterPos : extreme_next;
        min_reached_d = emit ? 1'b0 : reached;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q    <= CenterPos;
      prev_time_q   <= '0;
      extreme_q     <= CenterPos;
      min_reached_q <= 1'b0;
    end else begin
      prev_pos_q    <= prev_pos_d;
      prev_time_q   <= prev_time_d;
      extreme_q     <= extreme_d;
      min_reached_q <= min_reached_d;
    end
  end

  // two-entry queue toward the back end
  assign full_o    = count_q == 2'd2;
  assign q_valid_o = count_q != 2'd0;
  assign q_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(accept) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ervt_div.sv @@
`default_nettype none
module ervt_div import ervt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [VelW-1:0] dividend_i,
  input  wire logic [VelW-1:0] divisor_i,
  output logic                 done_o,
  output logic [VelW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(VelW);

  logic [VelW-1:0] rem_q, quo_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [VelW:0]   shifted;
  logic            ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[VelW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? VelW'(shifted - {1'b0, dvs_q}) : VelW'(shifted);
      quo_q <= {quo_q[VelW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(VelW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

@@ hw/rtl/ervt_back.sv @@
`default_nettype none
module ervt_back import ervt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire ervt_cmd_t  q_entry_i,
  output logic            q_pop_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output ervt_res_t       res_o
);

  ervt_back_state_e state_q, state_d;
  ervt_cmd_t        ent_q;

  logic [VelW-1:0] peak_q, sum_q, cnt_q, pvel_q, mean_q, mean_d;
  logic            mean_en;
  logic            clr, upd_en;
  logic [VelW-1:0] upd_vel;

  logic            div_start, div_done;
  logic [VelW-1:0] div_a, div_b, div_quo;

  ervt_res_t  rmem_q [2];
  logic       rwr_q, rrd_q;
  logic [1:0] rcnt_q;
  logic       res_full, res_push, res_pop;

  ervt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    div_a     = {{(VelW-ScaledW){1'b0}}, q_entry_i.scaled};
    div_b     = q_entry_i.elapsed;
    upd_en    = 1'b0;
    upd_vel   = div_quo;
    clr       = 1'b0;
    mean_en   = 1'b0;
    mean_d    = div_quo;
    res_push  = 1'b0;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.is_start) begin
            clr = 1'b1;
          end else if (q_entry_i.followed) begin
            if (q_entry_i.elapsed == '0) begin
              // no time gone by: velocity saturates
              upd_en  = 1'b1;
              upd_vel = '1;
              state_d = q_entry_i.emit ? BkMean : BkIdle;
            end else begin
              div_start = 1'b1;
              state_d   = BkVel;
            end
          end else begin
            state_d = q_entry_i.emit ? BkMean : BkIdle;
          end
        end
      end
      BkVel: begin
        if (div_done) begin
          upd_en  = 1'b1;
          state_d = ent_q.emit ? BkMean : BkIdle;
        end
      end
      BkMean: begin
        if (cnt_q == '0) begin
          mean_en = 1'b1;
          mean_d  = '0;
          state_d = BkPush;
        end else begin
          div_start = 1'b1;
          div_a     = sum_q;
          div_b     = cnt_q;
          state_d   = BkMeanWait;
        end
      end
      BkMeanWait: begin
        if (div_done) begin
          mean_en = 1'b1;
          state_d = BkPush;
        end
      end
      BkPush: begin
        if (!res_full) begin
          res_push = 1'b1;
          clr      = 1'b1;
          state_d  = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      peak_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      pvel_q  <= '0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        peak_q <= '0;
        sum_q  <= '0;
        cnt_q  <= '0;
        pvel_q <= '0;
      end else if (upd_en) begin
        if (upd_vel > peak_q) begin
          peak_q <= upd_vel;
        end
        if (upd_vel > pvel_q) begin
          cnt_q <= cnt_q + VelW'(1);
          sum_q <= sum_q + upd_vel;
        end
        pvel_q <= upd_vel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_entry_i;
    end
    if (mean_en) begin
      mean_q <= mean_d;
    end
  end

  // two-entry result queue
  assign res_full = rcnt_q == 2'd2;
  assign empty_o  = rcnt_q == 2'd0;
  assign res_pop  = pop_i && !empty_o;
  assign res_o    = rmem_q[rrd_q];

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rmem_q[rwr_q] <= '{extreme: ent_q.extreme, mean: mean_q, peak: peak_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        rwr_q <= !rwr_q;
      end
      if (res_pop) begin
        rrd_q <= !rrd_q;
      end
      rcnt_q <= rcnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/encoder_rep_velocity_tracker.sv @@
// front end classifies one item per cycle into a two-entry queue, unless it is full
// back end takes one item at a time: it waits on the divider when the item needs a velocity,
// then, when the item closes a repetition, for the mean (skipped when no velocity rose)
// and pushes the result; no new item is taken until the last one is done
// results wait in a two-entry queue
// async active-low reset clears all trackers, queues and config (0, 1, 1)
`default_nettype none
module encoder_rep_velocity_tracker import ervt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic               command_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [TimeW-1:0]   capture_time_i,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic [PosW-1:0]         extreme_position_o,
  output logic [VelW-1:0]         mean_velocity_o,
  output logic [VelW-1:0]         peak_velocity_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TravelW-1:0] cfg_wdata_i
);

  logic [TravelW-1:0] min_travel_q;
  logic               count_dir_q, rep_dir_q;
  logic               q_valid, q_pop;
  ervt_cmd_t          q_entry;
  ervt_res_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_travel_q <= '0;
      count_dir_q  <= 1'b1;
      rep_dir_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMinTravel: min_travel_q <= cfg_wdata_i;
        CfgCountDir:  count_dir_q  <= cfg_wdata_i[0];
        CfgRepDir:    rep_dir_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  ervt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .command_i      (command_i),
    .position_i     (position_i),
    .capture_time_i (capture_time_i),
    .full_o         (full_o),
    .min_travel_i   (min_travel_q),
    .count_dir_i    (count_dir_q),
    .rep_dir_i      (rep_dir_q),
    .q_pop_i        (q_pop),
    .q_valid_o      (q_valid),
    .q_entry_o      (q_entry)
  );

  ervt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .res_o     (res)
  );

  assign extreme_position_o = res.extreme;
  assign mean_velocity_o    = res.mean;
  assign peak_velocity_o    = res.peak;

endmodule
`default_nettype wire
